### rtl/core/ucm_pkg.sv
package ucm_pkg;

  // Width of one code point.
  localparam int CpW = 21;

  typedef logic [CpW-1:0] cp_t;

  // Values that the fixed one-to-one rules produce.
  typedef logic [8:0] fixed_t;

  // Signed step added to a code point by the offset rules.
  typedef logic signed [7:0] delta_t;

  // Values for the action input.
  localparam logic ACT_UPPER = 1'b0;
  localparam logic ACT_LOWER = 1'b1;

  // Mapping rule picked by the classifier.
  typedef enum logic [3:0] {
    RULE_NONE,
    RULE_PLUS20,
    RULE_MINUS20,
    RULE_PLUS30,
    RULE_MINUS30,
    RULE_PLUS50,
    RULE_MINUS50,
    RULE_ODD_DOWN,
    RULE_EVEN_UP,
    RULE_EVEN_DOWN,
    RULE_ODD_UP,
    RULE_FIXED
  } rule_t;

  // Results of the special cases.
  localparam fixed_t FIX_Y_DIAER_CAP = 9'h178;
  localparam fixed_t FIX_Y_DIAER_SML = 9'h0FF;
  localparam fixed_t FIX_I_CAP       = 9'h049;
  localparam fixed_t FIX_I_SML       = 9'h069;
  localparam fixed_t FIX_S_CAP       = 9'h053;

  // Code points that the special cases test for.
  localparam cp_t CP_Y_DIAER_CAP = 21'h00178;
  localparam cp_t CP_Y_DIAER_SML = 21'h000FF;
  localparam cp_t CP_I_DOT       = 21'h00130;
  localparam cp_t CP_I_DOTLESS   = 21'h00131;
  localparam cp_t CP_LONG_S      = 21'h0017F;

  // Step sizes of the offset rules.
  localparam delta_t DLT_20  = 8'sd32;
  localparam delta_t DLT_30  = 8'sd48;
  localparam delta_t DLT_50  = 8'sd80;
  localparam delta_t DLT_ONE = 8'sd1;
  localparam delta_t DLT_NIL = 8'sd0;

  // Classifier result carried in the first stage.
  typedef struct packed {
    rule_t  rule;
    fixed_t fixed;
  } class_t;

  // Offset result carried in the second stage.
  typedef struct packed {
    logic   use_fixed;
    fixed_t fixed;
    delta_t delta;
  } offs_t;

  // True when c lies in lo..hi, both inclusive.
  function automatic logic in_rng(input cp_t c, input cp_t lo, input cp_t hi);
    in_rng = (c >= lo) && (c <= hi);
  endfunction

endpackage

### rtl/core/ucm_classify.sv
module ucm_classify import ucm_pkg::*; (
  input  logic   action,
  input  cp_t    code_point,
  output class_t cls
);

  // Upper-casing rules; where ranges overlap, the first matching test wins.
  class_t up_cls;
  always_comb begin
    up_cls.rule  = RULE_NONE;
    up_cls.fixed = '0;
    if (in_rng(code_point, 21'h61, 21'h7A)) begin
      up_cls.rule = RULE_MINUS20;
    end else if (in_rng(code_point, 21'hE0, 21'hF6) || in_rng(code_point, 21'hF8, 21'hFE)) begin
      up_cls.rule = RULE_MINUS20;
    end else if (code_point == CP_Y_DIAER_SML) begin
      up_cls.rule  = RULE_FIXED;
      up_cls.fixed = FIX_Y_DIAER_CAP;
    end else if (code_point == CP_I_DOT || code_point == CP_I_DOTLESS) begin
      up_cls.rule  = RULE_FIXED;
      up_cls.fixed = FIX_I_CAP;
    end else if (in_rng(code_point, 21'h100, 21'h137) ||
                 in_rng(code_point, 21'h14A, 21'h177)) begin
      up_cls.rule = RULE_ODD_DOWN;
    end else if (in_rng(code_point, 21'h139, 21'h148) ||
                 in_rng(code_point, 21'h179, 21'h17E)) begin
      up_cls.rule = RULE_EVEN_DOWN;
    end else if (code_point == CP_LONG_S) begin
      up_cls.rule  = RULE_FIXED;
      up_cls.fixed = FIX_S_CAP;
    end else if (in_rng(code_point, 21'h200, 21'h217)) begin
      up_cls.rule = RULE_ODD_DOWN;
    end else if (in_rng(code_point, 21'h430, 21'h44F)) begin
      up_cls.rule = RULE_MINUS20;
    end else if (in_rng(code_point, 21'h451, 21'h45C) ||
                 in_rng(code_point, 21'h45E, 21'h45F)) begin
      up_cls.rule = RULE_MINUS50;
    end else if (in_rng(code_point, 21'h460, 21'h47F)) begin
      up_cls.rule = RULE_ODD_DOWN;
    end else if (in_rng(code_point, 21'h561, 21'h586)) begin
      up_cls.rule = RULE_MINUS30;
    end else if (in_rng(code_point, 21'hFF41, 21'hFF5A)) begin
      up_cls.rule = RULE_MINUS20;
    end
  end

  // Lower-casing rules; where ranges overlap, the first matching test wins.
  class_t lo_cls;
  always_comb begin
    lo_cls.rule  = RULE_NONE;
    lo_cls.fixed = '0;
    if (in_rng(code_point, 21'h41, 21'h5A)) begin
      lo_cls.rule = RULE_PLUS20;
    end else if (in_rng(code_point, 21'hC0, 21'hD6) || in_rng(code_point, 21'hD8, 21'hDE)) begin
      lo_cls.rule = RULE_PLUS20;
    end else if (code_point == CP_I_DOT || code_point == CP_I_DOTLESS) begin
      lo_cls.rule  = RULE_FIXED;
      lo_cls.fixed = FIX_I_SML;
    end else if (in_rng(code_point, 21'h100, 21'h137) ||
                 in_rng(code_point, 21'h14A, 21'h177)) begin
      lo_cls.rule = RULE_EVEN_UP;
    end else if (code_point == CP_Y_DIAER_CAP) begin
      lo_cls.rule  = RULE_FIXED;
      lo_cls.fixed = FIX_Y_DIAER_SML;
    end else if (in_rng(code_point, 21'h139, 21'h148) ||
                 in_rng(code_point, 21'h179, 21'h17E)) begin
      lo_cls.rule = RULE_ODD_UP;
    end else if (in_rng(code_point, 21'h200, 21'h217)) begin
      lo_cls.rule = RULE_EVEN_UP;
    end else if (in_rng(code_point, 21'h401, 21'h40C) ||
                 in_rng(code_point, 21'h40E, 21'h40F)) begin
      lo_cls.rule = RULE_PLUS50;
    end else if (in_rng(code_point, 21'h410, 21'h42F)) begin
      lo_cls.rule = RULE_PLUS20;
    end else if (in_rng(code_point, 21'h460, 21'h47F)) begin
      lo_cls.rule = RULE_EVEN_UP;
    end else if (in_rng(code_point, 21'h531, 21'h556)) begin
      lo_cls.rule = RULE_PLUS30;
    end else if (in_rng(code_point, 21'h10A0, 21'h10C5)) begin
      lo_cls.rule = RULE_PLUS30;
    end else if (in_rng(code_point, 21'hFF21, 21'hFF3A)) begin
      lo_cls.rule = RULE_PLUS20;
    end
  end

  // The action bit picks the rule set.
  assign cls = (action == ACT_LOWER) ? lo_cls : up_cls;

endmodule

### rtl/core/ucm_offset.sv
module ucm_offset import ucm_pkg::*; (
  input  class_t cls,
  input  logic   cp_odd,
  output offs_t  offs
);

  // Turn the rule and the parity of the code point into a signed step.
  always_comb begin
    offs.use_fixed = 1'b0;
    offs.fixed     = cls.fixed;
    offs.delta     = DLT_NIL;
    case (cls.rule)
      RULE_NONE:      offs.delta = DLT_NIL;
      RULE_PLUS20:    offs.delta = DLT_20;
      RULE_MINUS20:   offs.delta = -DLT_20;
      RULE_PLUS30:    offs.delta = DLT_30;
      RULE_MINUS30:   offs.delta = -DLT_30;
      RULE_PLUS50:    offs.delta = DLT_50;
      RULE_MINUS50:   offs.delta = -DLT_50;
      RULE_ODD_DOWN:  offs.delta = cp_odd ? -DLT_ONE : DLT_NIL;
      RULE_EVEN_UP:   offs.delta = cp_odd ? DLT_NIL : DLT_ONE;
      RULE_EVEN_DOWN: offs.delta = cp_odd ? DLT_NIL : -DLT_ONE;
      RULE_ODD_UP:    offs.delta = cp_odd ? DLT_ONE : DLT_NIL;
      RULE_FIXED:     offs.use_fixed = 1'b1;
      default:        offs.delta = DLT_NIL;
    endcase
  end

endmodule

### rtl/core/unicode_case_mapper.sv
// Maps one Unicode code point per beat to upper case (in_action low) or lower case
// (in_action high) by fixed range rules covering ASCII, Latin-1, Latin Extended-A,
// part of Latin Extended-B, Cyrillic, Armenian, Georgian and fullwidth Latin; any
// other value, including values above 0x10FFFF, passes through unchanged. The block
// keeps no state between beats. It accepts one beat per cycle while the output is
// not stalled, and each result passes three registered stages: stage one classifies
// the code point by range compares, stage two turns the rule into a signed step or
// a fixed value, and stage three applies the 21-bit add into the output register.
// A stalled output backs up through the stages without losing or repeating a beat.
module unicode_case_mapper import ucm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  input  logic [20:0] in_code_point,
  output logic out_valid,
  input  logic out_ready,
  output logic [20:0] out_mapped_point
);

  logic   s1_valid_r, s2_valid_r, s3_valid_r;
  cp_t    s1_cp_r, s2_cp_r, s3_cp_r;
  class_t s1_cls_r;
  offs_t  s2_offs_r;
  cp_t    s3_mapped_r;

  class_t s1_cls_nxt;
  offs_t  s2_offs_nxt;
  cp_t    s3_mapped_nxt;
  logic   s1_ready, s2_ready, s3_ready;

  // A stage takes a new beat when it is empty or its content moves on.
  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  ucm_classify u_classify (
    .action     (in_action),
    .code_point (in_code_point),
    .cls        (s1_cls_nxt)
  );

  ucm_offset u_offset (
    .cls    (s1_cls_r),
    .cp_odd (s1_cp_r[0]),
    .offs   (s2_offs_nxt)
  );

  // Final value: a fixed code point or the input plus the sign-extended step.
  assign s3_mapped_nxt = s2_offs_r.use_fixed
      ? {{(CpW-9){1'b0}}, s2_offs_r.fixed}
      : s2_cp_r + {{(CpW-8){s2_offs_r.delta[7]}}, s2_offs_r.delta};

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  // Payload registers move together with their valid bits.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_cp_r  <= in_code_point;
      s1_cls_r <= s1_cls_nxt;
    end
    if (s2_ready) begin
      s2_cp_r   <= s1_cp_r;
      s2_offs_r <= s2_offs_nxt;
    end
    if (s3_ready) begin
      s3_cp_r     <= s2_cp_r;
      s3_mapped_r <= s3_mapped_nxt;
    end
  end

  assign out_valid        = s3_valid_r;
  assign out_mapped_point = s3_mapped_r;

  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
      !rst_n |=> (!s1_valid_r && !s2_valid_r && !s3_valid_r))
    else $error("pipeline not empty after reset");

  // A beat in stage two is never dropped while stage three is blocked.
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (s2_valid_r && !s3_ready) |=> (s2_valid_r && $stable(s2_cp_r)))
    else $error("stage two lost a beat during a stall");

  // A beat in stage one moves to stage two when stage two can take it.
  a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
      (s1_valid_r && s2_ready) |=> s2_valid_r)
    else $error("stage one beat did not advance");

  // Code points above the sixteen-bit plane always pass through unchanged.
  a_high_pass: assert property (@(posedge clk) disable iff (!rst_n)
      (s3_valid_r && (s3_cp_r[CpW-1:16] != '0)) |-> (s3_mapped_r == s3_cp_r))
    else $error("code point outside the mapped planes was altered");

endmodule

### tb/ucm_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the case mapper, predicts each mapped code point
// and compares it with the beats that leave the block, oldest first.
module ucm_checker import ucm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic in_action,
  input  logic [20:0] in_code_point,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [20:0] out_mapped_point,
  output int error_count,
  output int points_in_flight
);

  // One accepted input beat together with the code point it should become.
  typedef struct {
    logic action;
    cp_t  code_point;
    cp_t  mapped_point;
  } mapping_t;

  mapping_t expected_mappings[$];

  function automatic logic in_span(input cp_t c, input int lo, input int hi);
    return (c >= cp_t'(lo)) && (c <= cp_t'(hi));
  endfunction

  // Upper-casing rules. Code points below the Latin-1 letters stop early.
  function automatic cp_t to_upper(input cp_t c);
    if (in_span(c, 'h61, 'h7A)) return c - 21'h20;
    if (c < 21'hE0) return c;
    if (in_span(c, 'hE0, 'hF6) || in_span(c, 'hF8, 'hFE)) return c - 21'h20;
    if (c == CP_Y_DIAER_SML) return cp_t'(FIX_Y_DIAER_CAP);
    if (in_span(c, 'h100, 'h137) || in_span(c, 'h14A, 'h177)) begin
      // Dotted and dotless I both become plain capital I.
      if (c == CP_I_DOT || c == CP_I_DOTLESS) return cp_t'(FIX_I_CAP);
      return c[0] ? c - 21'h1 : c;
    end
    if (in_span(c, 'h139, 'h148) || in_span(c, 'h179, 'h17E)) return c[0] ? c : c - 21'h1;
    if (c == CP_LONG_S) return cp_t'(FIX_S_CAP);
    if (in_span(c, 'h200, 'h217)) return c[0] ? c - 21'h1 : c;
    if (in_span(c, 'h430, 'h44F)) return c - 21'h20;
    if (in_span(c, 'h451, 'h45C) || in_span(c, 'h45E, 'h45F)) return c - 21'h50;
    if (in_span(c, 'h460, 'h47F)) return c[0] ? c - 21'h1 : c;
    if (in_span(c, 'h561, 'h586)) return c - 21'h30;
    if (in_span(c, 'hFF41, 'hFF5A)) return c - 21'h20;
    return c;
  endfunction

  // Lower-casing rules. Georgian capitals are only mapped in this direction.
  function automatic cp_t to_lower(input cp_t c);
    if (in_span(c, 'h41, 'h5A)) return c + 21'h20;
    if (c < 21'hC0) return c;
    if (in_span(c, 'hC0, 'hD6) || in_span(c, 'hD8, 'hDE)) return c + 21'h20;
    if (in_span(c, 'h100, 'h137) || in_span(c, 'h14A, 'h177)) begin
      if (c == CP_I_DOT || c == CP_I_DOTLESS) return cp_t'(FIX_I_SML);
      return c[0] ? c : c + 21'h1;
    end
    if (c == CP_Y_DIAER_CAP) return cp_t'(FIX_Y_DIAER_SML);
    if (in_span(c, 'h139, 'h148) || in_span(c, 'h179, 'h17E)) return c[0] ? c + 21'h1 : c;
    if (in_span(c, 'h200, 'h217)) return c[0] ? c : c + 21'h1;
    if (in_span(c, 'h401, 'h40C) || in_span(c, 'h40E, 'h40F)) return c + 21'h50;
    if (in_span(c, 'h410, 'h42F)) return c + 21'h20;
    if (in_span(c, 'h460, 'h47F)) return c[0] ? c : c + 21'h1;
    if (in_span(c, 'h531, 'h556)) return c + 21'h30;
    if (in_span(c, 'h10A0, 'h10C5)) return c + 21'h30;
    if (in_span(c, 'hFF21, 'hFF3A)) return c + 21'h20;
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: case mapper mismatch: %s", $time, what);
    error_count++;
  endtask

  initial begin
    error_count = 0;
    points_in_flight = 0;
  end

  // Compare outgoing beats first, then record the beat that enters.
  always @(posedge clk) begin
    mapping_t want;
    mapping_t got_in;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_mappings.size() == 0) begin
          report_mismatch($sformatf("output beat 0x%06h with nothing outstanding",
                                    out_mapped_point));
        end else begin
          want = expected_mappings.pop_front();
          if (out_mapped_point !== want.mapped_point)
            report_mismatch($sformatf("action %0d point 0x%06h gave 0x%06h, expected 0x%06h",
                                      want.action, want.code_point, out_mapped_point,
                                      want.mapped_point));
        end
      end
      if (in_valid && in_ready) begin
        got_in.action = in_action;
        got_in.code_point = in_code_point;
        got_in.mapped_point = (in_action == ACT_LOWER) ? to_lower(in_code_point)
                                                       : to_upper(in_code_point);
        expected_mappings.push_back(got_in);
      end
      points_in_flight <= expected_mappings.size();
    end
  end

endmodule

### tb/unicode_case_mapper_test.sv
`timescale 1ns / 100ps

// Drives code points into the case mapper under varying back-pressure and
// reports the verdict that the checker reaches.
module unicode_case_mapper_test;
  import ucm_pkg::*;

  localparam int BeatsPerPhase = 167;
  localparam int HoldOffCycles = 60;
  localparam int CycleLimit = 150000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_action;
  logic [20:0] in_code_point;
  logic out_valid;
  logic out_ready;
  logic [20:0] out_mapped_point;

  int error_count;
  int points_in_flight;
  int cycle_count;
  int idle_phase;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  logic hold_done;

  // Edge cases first: range ends, special letters, surrogates and huge values.
  logic [21:0] directed_beats [25] = '{
    {ACT_UPPER, 21'h000000}, {ACT_LOWER, 21'h1FFFFF}, {ACT_UPPER, 21'h000061},
    {ACT_UPPER, 21'h00007A}, {ACT_LOWER, 21'h000041}, {ACT_LOWER, 21'h00005A},
    {ACT_UPPER, 21'h0000FF}, {ACT_LOWER, 21'h000178}, {ACT_UPPER, 21'h000130},
    {ACT_LOWER, 21'h000131}, {ACT_UPPER, 21'h00017F}, {ACT_LOWER, 21'h00017F},
    {ACT_UPPER, 21'h0000F7}, {ACT_LOWER, 21'h0000D7}, {ACT_UPPER, 21'h000139},
    {ACT_LOWER, 21'h00017E}, {ACT_UPPER, 21'h000217}, {ACT_LOWER, 21'h000200},
    {ACT_UPPER, 21'h00045D}, {ACT_LOWER, 21'h00040D}, {ACT_LOWER, 21'h0010C5},
    {ACT_UPPER, 21'h0010D0}, {ACT_UPPER, 21'h00FF5A}, {ACT_LOWER, 21'h00FF21},
    {ACT_UPPER, 21'h00D800}
  };

  unicode_case_mapper i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_code_point(in_code_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mapped_point(out_mapped_point)
  );

  ucm_checker i_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_code_point(in_code_point),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mapped_point(out_mapped_point),
    .error_count(error_count),
    .points_in_flight(points_in_flight)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("unicode_case_mapper_test: done, errors");
      $finish;
    end
  end

  // Receiver side. The first beats of the last phase meet a long hold-off
  // so that the pipeline fills and pushes back on the sender.
  initial begin
    out_ready = 1'b0;
    hold_left = HoldOffCycles;
    hold_done = 1'b0;
  end
  always @(negedge clk) begin
    if (idle_phase == 2 && !hold_done) begin
      out_ready <= 1'b0;
      if (hold_left == 0) hold_done <= 1'b1;
      else hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Random code points, mostly aimed at the mapped blocks and their edges.
  function automatic cp_t pick_code_point();
    case ($urandom_range(0, 11))
      0: return cp_t'($urandom_range(0, 'hFF));
      1: return cp_t'($urandom_range('hF0, 'h18F));
      2: return cp_t'($urandom_range('h100, 'h17F));
      3: return cp_t'($urandom_range('h1F0, 'h220));
      4: return cp_t'($urandom_range('h3F0, 'h490));
      5: return cp_t'($urandom_range('h520, 'h590));
      6: return cp_t'($urandom_range('h1090, 'h10D0));
      7: return cp_t'($urandom_range('hFF10, 'hFF60));
      8: return cp_t'($urandom_range(0, 'hFFFF));
      9: return cp_t'($urandom_range(0, 'h10FFFF));
      default: return cp_t'($urandom);
    endcase
  endfunction

  // Offer one beat, starting and ending at a falling edge. Valid is lowered
  // only for an idle gap, never between two back-to-back beats.
  task automatic send_point(input logic action, input cp_t code_point);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= action;
    in_code_point <= code_point;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_UPPER;
    in_code_point = '0;
    idle_phase = 0;
    tx_idle_pct = 35;
    rx_idle_pct = 52;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_beats[i])
      send_point(directed_beats[i][21], directed_beats[i][20:0]);

    // Three idling phases: receiver-heavy, sender-heavy, then full rate.
    for (int phase = 0; phase < 3; phase++) begin
      idle_phase <= phase;
      tx_idle_pct <= (phase == 0) ? 35 : (phase == 1) ? 52 : 0;
      rx_idle_pct <= (phase == 0) ? 52 : (phase == 1) ? 35 : 0;
      @(negedge clk);
      for (int n = 0; n < BeatsPerPhase; n++)
        send_point(1'($urandom), pick_code_point());
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline depth plus margin for stray beats.
    while (points_in_flight != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("unicode_case_mapper_test: done, clean");
    end else begin
      $display("unicode_case_mapper_test: done, errors");
    end
    $finish;
  end

endmodule
